### hw/rtl/rsch_pkg.sv
package rsch_pkg;

    // operand widths of the shared divider and the sphere index width
    localparam int DivDw = 49;
    localparam int DivSw = 31;
    localparam int IdxW  = 8;

    localparam logic signed [63:0] S32Max = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] S32Min = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic signed [31:0] ray_org_x;
        logic signed [31:0] ray_org_y;
        logic signed [31:0] ray_org_z;
        logic signed [31:0] ray_dir_x;
        logic signed [31:0] ray_dir_y;
        logic signed [31:0] ray_dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
        logic               first_sphere;
        logic               last_sphere;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic        [30:0] hit_distance;
        logic        [7:0]  sphere_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } t_res;

    // multiplier operand pairs
    typedef enum logic [2:0] {
        MS_DD, MS_OD, MS_OO, MS_RR, MS_HH, MS_AC, MS_DT
    } t_msel;

    typedef enum logic [1:0] {
        AC_FIRST, AC_ADD, AC_SUB
    } t_acc_op;

    typedef enum logic [1:0] {
        Q_A, Q_HB, Q_C
    } t_qty;

    typedef enum logic [1:0] {
        DS_T0, DS_T1, DS_N
    } t_dsrc;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        t_msel      msel;
        logic       acc_en;
        t_acc_op    acc_op;
        logic       set_en;
        t_qty       qty;
        logic       disc_ld;
        logic       disc_sub;
        logic       sqrt_go;
        logic       div_go;
        t_dsrc      dsrc;
        logic       set_t;
        logic       upd;
        logic       pos_en;
        logic       set_n;
        logic       emit;
        logic [1:0] lane;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic ok;
        logic num0_pos;
        logic num1_pos;
        logic q_nz;
        logic better;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > S32Max) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32Min) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/rsch_if.sv
interface rsch_req_if;
    import rsch_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface rsch_res_if;
    import rsch_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/rsch_sqrt.sv
module rsch_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_val,
    output logic        o_busy,
    output logic [31:0] o_root
);
    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] sum;
    logic        ge;

    // two radicand bits are used and one result bit settles per step, one step a cycle
    assign sum = r_res + r_bit;
    assign ge  = (r_rem >= sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_go) begin
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_bit != '0) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_val;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (ge) begin
                r_rem <= r_rem - sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_res[31:0];
endmodule

### hw/rtl/rsch_div.sv
module rsch_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [rsch_pkg::DivDw-1:0]  i_dividend,
    input  logic [rsch_pkg::DivSw-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [rsch_pkg::DivDw-1:0]  o_quo
);
    import rsch_pkg::*;

    logic [DivSw-1:0] r_rem;
    logic [DivDw-1:0] r_quo;
    logic [DivSw-1:0] r_d;
    logic [5:0]       r_cnt;
    logic [DivSw:0]   tmp;
    logic [DivSw:0]   diff;
    logic             ge;

    // restoring division, one quotient bit a cycle
    assign tmp  = {r_rem, r_quo[DivDw-1]};
    assign ge   = (tmp >= {1'b0, r_d});
    assign diff = tmp - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_go) begin
            r_cnt <= 6'(DivDw);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DivSw-1:0] : tmp[DivSw-1:0];
            r_quo <= {r_quo[DivDw-2:0], ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule

### hw/rtl/rsch_dp.sv
module rsch_dp #(
    parameter int MAX_SPHERES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsch_pkg::t_cmd i_cmd,
    input  rsch_pkg::t_req i_req,
    output rsch_pkg::t_sts o_sts,
    output rsch_pkg::t_res o_res
);
    import rsch_pkg::*;

    localparam logic [IdxW-1:0] CntMax = IdxW'(MAX_SPHERES - 1);

    logic signed [31:0] r_org [3];
    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_cen [3];
    logic signed [31:0] r_oc  [3];
    logic        [30:0] r_rad;
    logic signed [65:0] r_prod;
    logic signed [50:0] r_acc;
    logic signed [31:0] r_a;
    logic signed [31:0] r_hb;
    logic signed [31:0] r_c;
    logic signed [64:0] r_disc;
    logic        [30:0] r_t;
    logic        [IdxW-1:0] r_idx;
    logic        [IdxW-1:0] r_cnt;
    logic               r_bvalid;
    logic        [30:0] r_bdist;
    logic        [IdxW-1:0] r_bidx;
    logic signed [31:0] r_bpos [3];
    logic signed [31:0] r_bnrm [3];
    logic               r_nsign;
    t_res               r_out;

    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [50:0] fl_prod;
    logic signed [50:0] psum;
    logic        [31:0] root;
    logic signed [33:0] nhb;
    logic signed [33:0] num0;
    logic signed [33:0] num1;
    logic signed [32:0] pdiff;
    logic        [32:0] pmag;
    logic        [DivDw-1:0] div_dvd;
    logic        [DivSw-1:0] div_dvs;
    logic        [DivDw-1:0] quo;
    logic               sqrt_busy;
    logic               div_busy;
    logic signed [49:0] nval;
    logic        [IdxW-1:0] ld_idx;
    logic signed [32:0] ocd [3];

    rsch_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_val   (r_disc[63:0]),
        .o_busy  (sqrt_busy),
        .o_root  (root)
    );

    rsch_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quo      (quo)
    );

    // operand select for the shared multiplier
    always_comb begin
        case (i_cmd.msel)
            MS_DD: begin
                op_a = 33'(r_dir[i_cmd.lane]);
                op_b = 33'(r_dir[i_cmd.lane]);
            end
            MS_OD: begin
                op_a = 33'(r_oc[i_cmd.lane]);
                op_b = 33'(r_dir[i_cmd.lane]);
            end
            MS_OO: begin
                op_a = 33'(r_oc[i_cmd.lane]);
                op_b = 33'(r_oc[i_cmd.lane]);
            end
            MS_RR: begin
                op_a = $signed({2'b00, r_rad});
                op_b = $signed({2'b00, r_rad});
            end
            MS_HH: begin
                op_a = 33'(r_hb);
                op_b = 33'(r_hb);
            end
            MS_AC: begin
                op_a = 33'(r_a);
                op_b = 33'(r_c);
            end
            MS_DT: begin
                op_a = 33'(r_dir[i_cmd.lane]);
                op_b = $signed({2'b00, r_t});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign fl_prod = 51'($signed(r_prod[65:16]));
    assign psum    = fl_prod + 51'(r_org[i_cmd.lane]);

    assign nhb  = -34'(r_hb);
    assign num0 = nhb - $signed({2'b00, root});
    assign num1 = nhb + $signed({2'b00, root});

    assign pdiff = 33'(r_bpos[i_cmd.lane]) - 33'(r_cen[i_cmd.lane]);
    assign pmag  = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);

    always_comb begin
        case (i_cmd.dsrc)
            DS_T1: begin
                div_dvd = {num1[32:0], 16'h0000};
                div_dvs = r_a[30:0];
            end
            DS_N: begin
                div_dvd = {pmag, 16'h0000};
                div_dvs = r_rad;
            end
            default: begin
                div_dvd = {num0[32:0], 16'h0000};
                div_dvs = r_a[30:0];
            end
        endcase
    end

    assign nval = r_nsign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

    assign ld_idx = i_req.first_sphere ? '0 : r_cnt;

    for (genvar g = 0; g < 3; g++) begin : g_oc
        assign ocd[g] = 33'(g == 0 ? i_req.ray_org_x : g == 1 ? i_req.ray_org_y
                                                              : i_req.ray_org_z)
                      - 33'(g == 0 ? i_req.center_x : g == 1 ? i_req.center_y
                                                             : i_req.center_z);
    end

    // request payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_org[0] <= i_req.ray_org_x;
            r_org[1] <= i_req.ray_org_y;
            r_org[2] <= i_req.ray_org_z;
            r_dir[0] <= i_req.ray_dir_x;
            r_dir[1] <= i_req.ray_dir_y;
            r_dir[2] <= i_req.ray_dir_z;
            r_cen[0] <= i_req.center_x;
            r_cen[1] <= i_req.center_y;
            r_cen[2] <= i_req.center_z;
            for (int k = 0; k < 3; k++) begin
                r_oc[k] <= sat32(64'(ocd[k]));
            end
            r_rad <= i_req.radius;
            r_idx <= ld_idx;
        end
        if (i_cmd.mul_en) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_op)
                AC_FIRST: r_acc <= fl_prod;
                AC_SUB:   r_acc <= r_acc - fl_prod;
                default:  r_acc <= r_acc + fl_prod;
            endcase
        end
        if (i_cmd.set_en) begin
            case (i_cmd.qty)
                Q_A:     r_a  <= sat32(64'(r_acc));
                Q_HB:    r_hb <= sat32(64'(r_acc));
                default: r_c  <= sat32(64'(r_acc));
            endcase
        end
        if (i_cmd.disc_ld) begin
            r_disc <= 65'(r_prod);
        end else if (i_cmd.disc_sub) begin
            r_disc <= r_disc - 65'(r_prod);
        end
        if (i_cmd.set_t) begin
            r_t <= (quo[DivDw-1:31] != '0) ? 31'h7FFF_FFFF : quo[30:0];
        end
        if (i_cmd.div_go) begin
            r_nsign <= pdiff[32];
        end
        if (i_cmd.emit) begin
            r_out.hit          <= r_bvalid;
            r_out.hit_distance <= r_bdist;
            r_out.sphere_index <= r_bidx;
            r_out.pos_x        <= r_bpos[0];
            r_out.pos_y        <= r_bpos[1];
            r_out.pos_z        <= r_bpos[2];
            r_out.normal_x     <= r_bnrm[0];
            r_out.normal_y     <= r_bnrm[1];
            r_out.normal_z     <= r_bnrm[2];
        end
    end

    // run state: kept hit and sphere counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit || (i_cmd.load && i_req.first_sphere)) begin
            r_bvalid <= 1'b0;
            r_bdist  <= '0;
            r_bidx   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_bpos[k] <= '0;
                r_bnrm[k] <= '0;
            end
        end else begin
            if (i_cmd.upd) begin
                r_bvalid <= 1'b1;
                r_bdist  <= r_t;
                r_bidx   <= r_idx;
            end
            if (i_cmd.pos_en) begin
                r_bpos[i_cmd.lane] <= sat32(64'(psum));
            end
            if (i_cmd.set_n) begin
                r_bnrm[i_cmd.lane] <= sat32(64'(nval));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= (ld_idx < CntMax) ? ld_idx + 1'b1 : ld_idx;
        end
    end

    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.ok        = (r_a > 32'sd0) && (r_rad != '0) && !r_disc[64];
    assign o_sts.num0_pos  = !num0[33] && (num0 != '0);
    assign o_sts.num1_pos  = !num1[33] && (num1 != '0);
    assign o_sts.q_nz      = (quo != '0);
    assign o_sts.better    = !r_bvalid || (r_t < r_bdist);
    assign o_res           = r_out;
endmodule

### hw/rtl/rsch_ctrl.sv
module rsch_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_last,
    input  logic           i_out_ready,
    input  rsch_pkg::t_sts i_sts,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output rsch_pkg::t_cmd o_cmd
);
    import rsch_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_MUL   = 16'h0002,
        ST_ACC   = 16'h0004,
        ST_SET   = 16'h0008,
        ST_HH    = 16'h0010,
        ST_DLD   = 16'h0020,
        ST_DSUB  = 16'h0040,
        ST_CHK   = 16'h0080,
        ST_SQRT  = 16'h0100,
        ST_DIV   = 16'h0200,
        ST_CMP   = 16'h0400,
        ST_PMUL  = 16'h0800,
        ST_POS   = 16'h1000,
        ST_NDIV  = 16'h2000,
        ST_NWAIT = 16'h4000,
        ST_END   = 16'h8000
    } t_state;

    t_state     r_state, n_state;
    t_qty       r_q, n_q;
    logic [1:0] r_l, n_l;
    logic       r_try1, n_try1;
    logic       r_last, n_last;
    logic       r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_q      = r_q;
        n_l      = r_l;
        n_try1   = r_try1;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd      = '0;
        o_cmd.lane = r_l;
        o_cmd.qty  = r_q;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_last     = i_last;
                    n_q        = Q_A;
                    n_l        = 2'd0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = (r_q == Q_A)  ? MS_DD :
                               (r_q == Q_HB) ? MS_OD :
                               (r_l == 2'd3) ? MS_RR : MS_OO;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc_en = 1'b1;
                o_cmd.acc_op = (r_l == 2'd0) ? AC_FIRST :
                               (r_l == 2'd3) ? AC_SUB : AC_ADD;
                if ((r_l == 2'd2 && r_q != Q_C) || r_l == 2'd3) begin
                    n_state = ST_SET;
                end else begin
                    n_l     = r_l + 2'd1;
                    n_state = ST_MUL;
                end
            end
            ST_SET: begin
                o_cmd.set_en = 1'b1;
                if (r_q == Q_C) begin
                    n_state = ST_HH;
                end else begin
                    n_q     = (r_q == Q_A) ? Q_HB : Q_C;
                    n_l     = 2'd0;
                    n_state = ST_MUL;
                end
            end
            ST_HH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_HH;
                n_state      = ST_DLD;
            end
            ST_DLD: begin
                o_cmd.disc_ld = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.msel    = MS_AC;
                n_state       = ST_DSUB;
            end
            ST_DSUB: begin
                o_cmd.disc_sub = 1'b1;
                n_state        = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.ok) begin
                    o_cmd.sqrt_go = 1'b1;
                    n_state       = ST_SQRT;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_SQRT: begin
                if (!i_sts.sqrt_busy) begin
                    if (i_sts.num0_pos) begin
                        o_cmd.div_go = 1'b1;
                        o_cmd.dsrc   = DS_T0;
                        n_try1       = 1'b0;
                        n_state      = ST_DIV;
                    end else if (i_sts.num1_pos) begin
                        o_cmd.div_go = 1'b1;
                        o_cmd.dsrc   = DS_T1;
                        n_try1       = 1'b1;
                        n_state      = ST_DIV;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.q_nz) begin
                        o_cmd.set_t = 1'b1;
                        n_state     = ST_CMP;
                    end else if (!r_try1 && i_sts.num1_pos) begin
                        o_cmd.div_go = 1'b1;
                        o_cmd.dsrc   = DS_T1;
                        n_try1       = 1'b1;
                    end else begin
                        n_state = ST_END;
                    end
                end
            end
            ST_CMP: begin
                if (i_sts.better) begin
                    o_cmd.upd = 1'b1;
                    n_l       = 2'd0;
                    n_state   = ST_PMUL;
                end else begin
                    n_state = ST_END;
                end
            end
            ST_PMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.msel   = MS_DT;
                n_state      = ST_POS;
            end
            ST_POS: begin
                o_cmd.pos_en = 1'b1;
                n_state      = ST_NDIV;
            end
            ST_NDIV: begin
                o_cmd.div_go = 1'b1;
                o_cmd.dsrc   = DS_N;
                n_state      = ST_NWAIT;
            end
            ST_NWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.set_n = 1'b1;
                    if (r_l == 2'd2) begin
                        n_state = ST_END;
                    end else begin
                        n_l     = r_l + 2'd1;
                        n_state = ST_PMUL;
                    end
                end
            end
            ST_END: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (!r_ovalid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_q      <= Q_A;
            r_l      <= 2'd0;
            r_try1   <= 1'b0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_q      <= n_q;
            r_l      <= n_l;
            r_try1   <= n_try1;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
endmodule

### hw/rtl/ray_sphere_closest_hit.sv
// channel   modport  direction  payload
// i_req     sink     in         one ray and one sphere, run marks (t_req)
// o_res     source   out        nearest hit of a run (t_res)
//
// one request at a time: a request ends early when the quadratic has no usable root
// or neither root numerator is positive, goes on through the root and the divisions
// when a hit is found but is not nearer, and also works out position and normal for a
// new nearest hit; the shared divider (up to five uses) and the 32-step square root
// take up most of its time; reset is synchronous and clears the kept hit, the counter and all handshakes
// the result sits in an output register, so new requests are taken while it
// waits; a run-ending request holds only if the previous result is still unread
module ray_sphere_closest_hit #(
    parameter int MAX_SPHERES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsch_req_if.sink   i_req,
    rsch_res_if.source o_res
);
    import rsch_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_res res;
    logic in_ready;
    logic out_valid;

    // sequencer: walks dot products, root, divisions and the hit update
    rsch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_last      (i_req.data.last_sphere),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // datapath: shared multiplier, square root, divider and run state
    rsch_dp #(
        .MAX_SPHERES (MAX_SPHERES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_sts   (sts),
        .o_res   (res)
    );

    assign i_req.ready = in_ready;
    assign o_res.valid = out_valid;
    assign o_res.data  = res;

    // a result is never loaded over one that has not been taken
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!out_valid || o_res.ready))
        else $error("result overwritten");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> out_valid)
        else $error("result not presented");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sqrt_go |-> (!sts.sqrt_busy && !sts.div_busy))
        else $error("square root restarted while busy");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_go |-> (!sts.div_busy && !sts.sqrt_busy))
        else $error("divider restarted while busy");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!sts.div_busy && !sts.sqrt_busy))
        else $error("request loaded during arithmetic");
endmodule
